// File: design/tdpt_pkg.sv
// Package for the trial-division prime tester: constants, microcode format and program.
package tdpt_pkg;

    localparam int DEF_VALUE_WIDTH = 32;

    localparam int TRIAL_FIRST = 5;
    localparam int TRIAL_STEP  = 6;
    localparam int TRIAL_PAIR  = 2;
    localparam int SMALL_DIV   = 3;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t S_IDLE     = 4'd0;
    localparam step_t S_SMALL    = 4'd1;
    localparam step_t S_WAIT3    = 4'd2;
    localparam step_t S_TRY_D    = 4'd3;
    localparam step_t S_WAIT_D   = 4'd4;
    localparam step_t S_TRY_D2   = 4'd5;
    localparam step_t S_WAIT_D2  = 4'd6;
    localparam step_t S_PASS     = 4'd7;
    localparam step_t S_FAIL     = 4'd8;
    localparam step_t S_START3   = 4'd9;

    typedef enum logic [2:0] {
        COND_ACCEPT,
        COND_SMALL,
        COND_ALWAYS,
        COND_DIV,
        COND_EMIT
    } cond_t;

    typedef enum logic [1:0] {
        DS_NONE,
        DS_THREE,
        DS_D,
        DS_D2
    } dsrc_t;

    typedef enum logic [1:0] {
        D_KEEP,
        D_FIRST,
        D_ADVANCE
    } dop_t;

    typedef struct packed {
        cond_t cond;
        dsrc_t dsrc;
        dop_t  dop;
        logic  lt_pass;
        logic  rz_fail;
        logic  verdict;
        step_t next;
    } ctrl_word_t;

    function automatic ctrl_word_t ucode(input step_t pc);
        ctrl_word_t cw;
        cw = '{cond: COND_ALWAYS, dsrc: DS_NONE, dop: D_KEEP, lt_pass: 1'b0,
               rz_fail: 1'b0, verdict: 1'b0, next: S_IDLE};
        unique case (pc)
            S_IDLE:    begin cw.cond = COND_ACCEPT; cw.next = S_SMALL; end
            S_SMALL:   begin cw.cond = COND_SMALL; cw.next = S_START3; end
            S_START3:  begin cw.dsrc = DS_THREE; cw.next = S_WAIT3; end
            S_WAIT3:
            begin
                cw.cond = COND_DIV; cw.rz_fail = 1'b1; cw.dop = D_FIRST; cw.next = S_TRY_D;
            end
            S_TRY_D:   begin cw.dsrc = DS_D; cw.next = S_WAIT_D; end
            S_WAIT_D:
            begin
                cw.cond = COND_DIV; cw.lt_pass = 1'b1; cw.rz_fail = 1'b1; cw.next = S_TRY_D2;
            end
            S_TRY_D2:  begin cw.dsrc = DS_D2; cw.next = S_WAIT_D2; end
            S_WAIT_D2:
            begin
                cw.cond = COND_DIV; cw.rz_fail = 1'b1; cw.dop = D_ADVANCE; cw.next = S_TRY_D;
            end
            S_PASS:    begin cw.cond = COND_EMIT; cw.verdict = 1'b1; cw.next = S_IDLE; end
            S_FAIL:    begin cw.cond = COND_EMIT; cw.verdict = 1'b0; cw.next = S_IDLE; end
            default:   begin cw.next = S_IDLE; end
        endcase
        return cw;
    endfunction

endpackage

// File: design/trial_division_prime_test_core.sv
// Trial-division prime tester: microcoded sequencer driving a shared restoring divider.
//
// Takes one unsigned candidate per item and returns one item with is_prime. A ten-word
// microcode table steps a datapath built around one restoring divider that yields one
// quotient bit per cycle; each division has an issue step, the divider run and a check
// step. Values below 4 and even values finish after the small-value check; otherwise one
// division by 3 is made and then two divisions per trial divisor pair d, d+2
// (d = 5, 11, 17, ...) until d exceeds n/d or a remainder is zero.
// A 32-bit prime near the top of the range needs roughly 10900 pairs. One item is worked
// at a time; the next is taken once the verdict has moved to the output register.
module trial_division_prime_test_core #(
    parameter int VALUE_WIDTH = tdpt_pkg::DEF_VALUE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [VALUE_WIDTH-1:0] candidate,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   is_prime,
    output logic                   out_valid,
    input  logic                   out_ready
);
    import tdpt_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    step_t                  pc_reg, pc_next;
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [VALUE_WIDTH-1:0] dvs_reg, dvs_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   div_busy_reg, div_busy_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   is_prime_reg, is_prime_next;
    ctrl_word_t             cw;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;

    assign in_ready  = (pc_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

    always_comb
    begin
        cw             = ucode(pc_reg);
        pc_next        = pc_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        dvs_next       = dvs_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        div_busy_next  = div_busy_reg;
        out_valid_next = out_valid_reg;
        is_prime_next  = is_prime_reg;

        trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        diff  = trial - {1'b0, dvs_reg};

        if (div_busy_reg)
        begin
            if (!diff[VALUE_WIDTH])
            begin
                rem_next = diff[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                div_busy_next = 1'b0;
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cw.dsrc != DS_NONE)
        begin
            rem_next      = '0;
            quo_next      = n_reg;
            cnt_next      = CNT_W'(VALUE_WIDTH);
            div_busy_next = 1'b1;
            case (cw.dsrc)
                DS_THREE: dvs_next = VALUE_WIDTH'(SMALL_DIV);
                DS_D:     dvs_next = d_reg;
                default:  dvs_next = d_reg + VALUE_WIDTH'(TRIAL_PAIR);
            endcase
        end

        unique case (cw.cond)
            COND_ACCEPT:
            begin
                if (in_valid)
                begin
                    n_next  = candidate;
                    pc_next = cw.next;
                end
            end
            COND_SMALL:
            begin
                if (n_reg <= VALUE_WIDTH'(1))
                    pc_next = S_FAIL;
                else if (n_reg <= VALUE_WIDTH'(SMALL_DIV))
                    pc_next = S_PASS;
                else if (!n_reg[0])
                    pc_next = S_FAIL;
                else
                    pc_next = cw.next;
            end
            COND_DIV:
            begin
                if (!div_busy_reg)
                begin
                    if (cw.lt_pass && (quo_reg < d_reg))
                        pc_next = S_PASS;
                    else if (cw.rz_fail && (rem_reg == '0))
                        pc_next = S_FAIL;
                    else
                    begin
                        pc_next = cw.next;
                        case (cw.dop)
                            D_FIRST:   d_next = VALUE_WIDTH'(TRIAL_FIRST);
                            D_ADVANCE: d_next = d_reg + VALUE_WIDTH'(TRIAL_STEP);
                            default:   d_next = d_reg;
                        endcase
                    end
                end
            end
            COND_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = cw.verdict;
                    pc_next        = cw.next;
                end
            end
            default:
            begin
                pc_next = cw.next;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= S_IDLE;
            div_busy_reg  <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            div_busy_reg  <= div_busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        d_reg        <= d_next;
        dvs_reg      <= dvs_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        is_prime_reg <= is_prime_next;
    end

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_busy_reg)
        else $error("divider busy while idle");

    a_accept_next_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (pc_reg == S_SMALL))
        else $error("accepted item did not start the program");

    a_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> (pc_reg == S_WAIT3 || pc_reg == S_WAIT_D || pc_reg == S_WAIT_D2))
        else $error("divider running outside a wait step");

    a_trial_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == S_TRY_D) |-> d_reg[0])
        else $error("trial divisor is even");

endmodule
